// File: rtl/bounded_int_list_engine_macros.svh
// Assertion macros used by the list engine checker
`ifndef BOUNDED_INT_LIST_ENGINE_MACROS_SVH
`define BOUNDED_INT_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BILE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BILE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bile_pkg.sv
// Types and constants of the bounded integer list engine
package bile_pkg;

    localparam int VAL_W  = 32;
    localparam int MODE_W = 3;
    localparam int ST_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND  = 3'd0,
        MODE_PREPEND = 3'd1,
        MODE_SORTED  = 3'd2,
        MODE_POP     = 3'd3,
        MODE_REVERSE = 3'd4,
        MODE_MID     = 3'd5
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_POP_RD,
        S_POP_CAP,
        S_MID_RD,
        S_MID_CAP,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        IDX_KEEP,
        IDX_ZERO,
        IDX_COUNT,
        IDX_HALF,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        FR_KEEP,
        FR_BACK,
        FR_FWD,
        FR_REV
    } t_front_op;

    typedef enum logic [1:0] {
        RS_IDX,
        RS_DEC,
        RS_INC
    } t_rd_sel;

    typedef enum logic {
        WS_VAL,
        WS_RD
    } t_wr_src;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic      load;
        t_status   status;
        t_idx_op   idx_op;
        logic      set_pos;
        t_front_op front_op;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      wr_en;
        t_wr_src   wr_src;
        t_cnt_op   cnt_op;
        logic      cap_removed;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic multi;
        logic idx_at_count;
        logic idx_at_pos;
        logic next_at_end;
        logic less;
    } t_dp_stat;

endpackage

// File: rtl/bile_if.sv
// Request and result channel interfaces of the list engine
interface bile_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               mode;
    logic signed [31:0]       value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface bile_out_if #(
    parameter int CNT_W = 7
);
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       removed_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;

    modport source (output valid, output removed_value, output status, output count,
                    input ready);
    modport sink (input valid, input removed_value, input status, input count,
                  output ready);
endinterface

// File: rtl/bile_ram.sv
// Generic single-write, single-read RAM with registered read data
module bile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/bile_dp.sv
// List engine datapath: ring pointers, cursors, element store and result registers
module bile_dp import bile_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int PW   = AW + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [VAL_W-1:0] i_value,
    output t_dp_stat                o_stat,
    output logic signed [VAL_W-1:0] o_removed_value,
    output t_status                 o_status,
    output logic [CW-1:0]           o_count
);

    logic [AW-1:0]           r_front, n_front;
    logic                    r_rev, n_rev;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_pos;
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_removed;
    t_status                 r_status;

    logic [CW-1:0]           rd_log;
    logic [CW-1:0]           fr_log;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [VAL_W-1:0]        wr_data;
    logic [VAL_W-1:0]        rd_data;

    // map a list position onto the ring, walking forward or backward from the front
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] front, input logic rev,
                                             input logic [CW-1:0] lidx);
        logic [PW-1:0] s;
        if (rev) begin
            s = PW'(front) + PW'(DEPTH) - PW'(lidx);
        end else begin
            s = PW'(front) + PW'(lidx);
        end
        if (s >= PW'(DEPTH)) begin
            s = s - PW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        case (i_cmd.rd_sel)
            RS_DEC:  rd_log = r_idx - CW'(1);
            RS_INC:  rd_log = r_idx + CW'(1);
            default: rd_log = r_idx;
        endcase
    end

    assign rd_addr = f_phys(r_front, r_rev, rd_log);
    assign wr_addr = f_phys(r_front, r_rev, r_idx);
    assign wr_data = (i_cmd.wr_src == WS_RD) ? rd_data : r_val;

    bile_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        case (i_cmd.front_op)
            FR_BACK: fr_log = CW'(DEPTH - 1);
            FR_FWD:  fr_log = CW'(1);
            FR_REV:  fr_log = r_count - CW'(1);
            default: fr_log = '0;
        endcase
        n_front = (i_cmd.front_op == FR_KEEP) ? r_front : f_phys(r_front, r_rev, fr_log);
        n_rev   = (i_cmd.front_op == FR_REV) ? !r_rev : r_rev;
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO:  n_idx = '0;
            IDX_COUNT: n_idx = r_count;
            IDX_HALF:  n_idx = r_count >> 1;
            IDX_INC:   n_idx = r_idx + CW'(1);
            IDX_DEC:   n_idx = r_idx - CW'(1);
            default:   n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rev   <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
            r_pos   <= '0;
        end else begin
            r_front <= n_front;
            r_rev   <= n_rev;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.set_pos) begin
                r_pos <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val     <= i_value;
            r_removed <= '0;
            r_status  <= i_cmd.status;
        end else if (i_cmd.cap_removed) begin
            r_removed <= rd_data;
        end
    end

    always_comb begin
        o_stat.full         = (r_count == CW'(DEPTH));
        o_stat.empty        = (r_count == '0);
        o_stat.multi        = (r_count > CW'(1));
        o_stat.idx_at_count = (r_idx == r_count);
        o_stat.idx_at_pos   = (r_idx == r_pos);
        o_stat.next_at_end  = ((PW'(r_idx) + PW'(1)) >= PW'(r_count));
        o_stat.less         = ($signed(rd_data) < r_val);
    end

    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_count         = r_count;

endmodule

// File: rtl/bile_ctrl.sv
// List engine controller: sequences reads, writes and pointer moves per request
module bile_ctrl import bile_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_out_free,
    input  t_dp_stat          i_stat,
    output logic              o_in_ready,
    output t_dp_cmd           o_cmd
);

    t_state r_state, n_state;
    t_mode  mode;

    assign mode = t_mode'(i_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (mode)
                        MODE_APPEND, MODE_PREPEND: n_state = i_stat.full ? S_DONE : S_INS_WR;
                        MODE_SORTED:  n_state = i_stat.full ? S_DONE : S_SCAN_RD;
                        MODE_POP:     n_state = i_stat.empty ? S_DONE : S_POP_RD;
                        MODE_MID:     n_state = i_stat.empty ? S_DONE : S_MID_RD;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_INS_WR:   n_state = S_DONE;
            S_SCAN_RD:  n_state = i_stat.idx_at_count ? S_SHIFT_RD : S_SCAN_CMP;
            S_SCAN_CMP: n_state = i_stat.less ? S_SCAN_RD : S_SHIFT_RD;
            S_SHIFT_RD: n_state = i_stat.idx_at_pos ? S_INS_WR : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_POP_RD:   n_state = S_POP_CAP;
            S_POP_CAP:  n_state = S_DONE;
            S_MID_RD:   n_state = S_MID_CAP;
            S_MID_CAP:  n_state = S_CLOSE_RD;
            S_CLOSE_RD: n_state = i_stat.next_at_end ? S_DONE : S_CLOSE_WR;
            S_CLOSE_WR: n_state = S_CLOSE_RD;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.status      = ST_OK;
        o_cmd.idx_op      = IDX_KEEP;
        o_cmd.set_pos     = 1'b0;
        o_cmd.front_op    = FR_KEEP;
        o_cmd.rd_en       = 1'b0;
        o_cmd.rd_sel      = RS_IDX;
        o_cmd.wr_en       = 1'b0;
        o_cmd.wr_src      = WS_VAL;
        o_cmd.cnt_op      = CNT_KEEP;
        o_cmd.cap_removed = 1'b0;
        o_cmd.out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (mode)
                        MODE_APPEND, MODE_PREPEND, MODE_SORTED: begin
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else if (mode == MODE_APPEND) begin
                                o_cmd.idx_op = IDX_COUNT;
                            end else if (mode == MODE_PREPEND) begin
                                o_cmd.idx_op   = IDX_ZERO;
                                o_cmd.front_op = FR_BACK;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                            end
                        end
                        MODE_POP, MODE_MID: begin
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.idx_op = (mode == MODE_POP) ? IDX_ZERO : IDX_HALF;
                            end
                        end
                        MODE_REVERSE: begin
                            if (i_stat.multi) begin
                                o_cmd.front_op = FR_REV;
                            end
                        end
                        default: o_cmd.status = ST_OK;
                    endcase
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WS_VAL;
                o_cmd.cnt_op = CNT_INC;
            end
            S_SCAN_RD: begin
                if (i_stat.idx_at_count) begin
                    o_cmd.set_pos = 1'b1;
                    o_cmd.idx_op  = IDX_COUNT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_IDX;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.less) begin
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    o_cmd.set_pos = 1'b1;
                    o_cmd.idx_op  = IDX_COUNT;
                end
            end
            S_SHIFT_RD: begin
                if (!i_stat.idx_at_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_DEC;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WS_RD;
                o_cmd.idx_op = IDX_DEC;
            end
            S_POP_RD, S_MID_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_IDX;
            end
            S_POP_CAP: begin
                o_cmd.cap_removed = 1'b1;
                o_cmd.front_op    = FR_FWD;
                o_cmd.cnt_op      = CNT_DEC;
            end
            S_MID_CAP: begin
                o_cmd.cap_removed = 1'b1;
            end
            S_CLOSE_RD: begin
                if (i_stat.next_at_end) begin
                    o_cmd.cnt_op = CNT_DEC;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_INC;
                end
            end
            S_CLOSE_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WS_RD;
                o_cmd.idx_op = IDX_INC;
            end
            S_DONE: begin
                o_cmd.out_load = i_out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// File: rtl/bounded_int_list_engine.sv
// Bounded integer list engine: one result per request.
// Append, prepend, reverse and refusals move no elements; pop reads the front element;
// middle removal and sorted insert walk the list element by element over the single RAM port pair.
// One request is in work at a time; the next is taken in the cycle after the result loads.
// Synchronous reset empties the list and clears the FSM; stored elements are not cleared.
module bounded_int_list_engine import bile_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bile_in_if.sink     i_in,
    bile_out_if.source  o_out
);

    t_dp_cmd                 cmd;
    t_dp_stat                stat;
    logic                    in_ready;
    logic                    out_free;
    logic signed [VAL_W-1:0] dp_removed;
    t_status                 dp_status;
    logic [CW-1:0]           dp_count;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_removed;
    t_status                 r_out_status;
    logic [CW-1:0]           r_out_count;

    assign out_free = !r_out_valid || o_out.ready;

    bile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_mode     (i_in.mode),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    bile_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value         (i_in.value),
        .o_stat          (stat),
        .o_removed_value (dp_removed),
        .o_status        (dp_status),
        .o_count         (dp_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_removed <= dp_removed;
            r_out_status  <= dp_status;
            r_out_count   <= dp_count;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_out_removed;
    assign o_out.status        = r_out_status;
    assign o_out.count         = r_out_count;

endmodule

// File: rtl/bile_chk.sv
// Port-level checker for the list engine and its bind
`include "bounded_int_list_engine_macros.svh"

module bile_chk import bile_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [VAL_W-1:0] i_out_removed,
    input logic [ST_W-1:0]         i_out_status,
    input logic [CW-1:0]           i_out_count
);

    `BILE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_removed) && $stable(i_out_status) && $stable(i_out_count), "result item changed while stalled")
    `BILE_ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_FULL), (i_out_count == CW'(DEPTH)) && (i_out_removed == '0), "full status without a full list")
    `BILE_ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_EMPTY), (i_out_count == '0) && (i_out_removed == '0), "empty status without an empty list")
    `BILE_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, i_out_valid, i_out_count <= CW'(DEPTH), "element count beyond depth")

endmodule

bind bounded_int_list_engine bile_chk #(
    .DEPTH (DEPTH)
) u_bile_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_removed (o_out.removed_value),
    .i_out_status  (o_out.status),
    .i_out_count   (o_out.count)
);

// File: bench/tb.sv
// Self-checking bench for the bounded integer list engine: queued requests, a list predictor
module tb;
    import bile_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_PCT     = 6;
    localparam int QUIET_FROM   = 20000;
    localparam int QUIET_TO     = 50000;

    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } t_list_req;

    typedef struct {
        logic signed [31:0] removed;
        t_status            status;
        logic [6:0]         count;
    } t_list_result;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } t_phase;

    logic clk;
    logic rst_n;

    bile_in_if               in_if ();
    bile_out_if #(.CNT_W(7)) out_if ();

    bounded_int_list_engine #(.DEPTH(DEPTH)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_list_req          pending_q[$];
    t_list_result       expected_q[$];
    logic signed [31:0] list_q[$];
    t_list_req          next_req;
    t_list_result       want;
    int                 accepted_cnt;
    int                 total_reqs;
    int                 error_cnt;
    int                 cycle_cnt;

    t_phase             phase;
    int                 phase_len;
    int                 random_cnt;
    int                 ins_pct;
    int                 roll;
    logic [2:0]         pick_mode;

    function automatic t_list_result apply_list_op(logic [2:0] mode, logic signed [31:0] value);
        t_list_result       res;
        int                 pos;
        int                 lo;
        int                 hi;
        logic signed [31:0] tmp;
        res.removed = '0;
        res.status  = ST_OK;
        case (mode)
            MODE_APPEND, MODE_PREPEND, MODE_SORTED: begin
                if (list_q.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (mode == MODE_APPEND) begin
                    list_q.push_back(value);
                end else if (mode == MODE_PREPEND) begin
                    list_q.push_front(value);
                end else begin
                    pos = 0;
                    while (pos < list_q.size() && list_q[pos] < value)
                        pos++;
                    list_q.insert(pos, value);
                end
            end
            MODE_POP, MODE_MID: begin
                if (list_q.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = (mode == MODE_POP) ? 0 : list_q.size() / 2;
                    res.removed = list_q[pos];
                    list_q.delete(pos);
                end
            end
            MODE_REVERSE: begin
                lo = 0;
                hi = list_q.size() - 1;
                while (lo < hi) begin
                    tmp        = list_q[lo];
                    list_q[lo] = list_q[hi];
                    list_q[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            default: ;
        endcase
        res.count = 7'(list_q.size());
        return res;
    endfunction

    function automatic logic side_idles();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3, 4: return $urandom_range(0, 15) - 8;
            5:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(logic [2:0] mode, logic signed [31:0] value);
        t_list_req req;
        req.mode  = mode;
        req.value = value;
        pending_q.push_back(req);
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.mode   = '0;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                expected_q.push_back(apply_list_op(in_if.mode, in_if.value));
                accepted_cnt++;
            end
            if (pending_q.size() != 0 && !side_idles()) begin
                next_req = pending_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.mode  <= next_req.mode;
                in_if.value <= next_req.value;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected item: removed %0d status %0d count %0d", $time,
                             out_if.removed_value, out_if.status, out_if.count);
                    error_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (out_if.removed_value !== want.removed) begin
                        $display("%0t: removed_value expected %0d actual %0d", $time,
                                 want.removed, out_if.removed_value);
                        error_cnt++;
                    end
                    if (out_if.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, out_if.status);
                        error_cnt++;
                    end
                    if (out_if.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d", $time,
                                 want.count, out_if.count);
                        error_cnt++;
                    end
                end
            end
            out_if.ready <= !side_idles();
        end
    end

    initial begin
        accepted_cnt = 0;
        error_cnt    = 0;
        cycle_cnt    = 0;
        random_cnt   = 0;

        add_req(MODE_POP, $urandom);
        add_req(MODE_MID, $urandom);
        add_req(MODE_REVERSE, $urandom);
        add_req(MODE_UNUSED_LO, $urandom);
        add_req(MODE_UNUSED_HI, $urandom);
        add_req(MODE_APPEND, VAL_MAX);
        add_req(MODE_MID, '0);
        add_req(MODE_APPEND, VAL_MIN);
        add_req(MODE_REVERSE, '0);
        add_req(MODE_PREPEND, VAL_MAX);
        add_req(MODE_SORTED, -32'sd1);
        add_req(MODE_SORTED, -32'sd1);
        add_req(MODE_SORTED, VAL_MIN);
        add_req(MODE_SORTED, VAL_MAX);
        add_req(MODE_APPEND, 32'sd5);
        add_req(MODE_REVERSE, '0);
        add_req(MODE_MID, '0);
        add_req(MODE_POP, '0);
        add_req(MODE_MID, '0);
        add_req(MODE_PREPEND, '0);
        add_req(MODE_SORTED, 32'sd3);
        add_req(MODE_REVERSE, '1);
        add_req(MODE_POP, '1);
        add_req(MODE_POP, '1);

        // start with a fill so the full list is reached early
        phase = PH_FILL;
        while (random_cnt < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 120);
            ins_pct   = (phase == PH_FILL) ? 85 : (phase == PH_DRAIN) ? 12 : 50;
            for (int k = 0; k < phase_len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    add_req(roll == 0 ? MODE_UNUSED_LO : MODE_UNUSED_HI, $urandom);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6) begin
                        pick_mode = MODE_REVERSE;
                    end else if (roll < 6 + ins_pct * 94 / 100) begin
                        case ($urandom_range(0, 3))
                            0:       pick_mode = MODE_APPEND;
                            1:       pick_mode = MODE_PREPEND;
                            default: pick_mode = MODE_SORTED;
                        endcase
                    end else begin
                        pick_mode = $urandom_range(0, 1) ? MODE_POP : MODE_MID;
                    end
                    add_req(pick_mode, pick_value());
                    random_cnt++;
                end
            end
            case ($urandom_range(0, 2))
                0:       phase = PH_FILL;
                1:       phase = PH_DRAIN;
                default: phase = PH_MIX;
            endcase
        end
        total_reqs = pending_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (accepted_cnt != total_reqs || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/bile_pkg.sv
rtl/bile_if.sv
rtl/bile_ram.sv
rtl/bile_dp.sv
rtl/bile_ctrl.sv
rtl/bounded_int_list_engine.sv
rtl/bile_chk.sv
bench/tb.sv
